[rtl/ksh_pkg.sv]
// Package: shared types, codes and field widths of the keyed share table.
`default_nettype none
package ksh_pkg;

   localparam int ID_W    = 31;
   localparam int VAL_W   = 32;
   localparam int TOT_W   = 38;
   localparam int FRAC_W  = 16;
   localparam int COUNT_W = 7;

   typedef logic [1:0] func_type;
   localparam func_type FN_UPDATE   = 2'd0;
   localparam func_type FN_LOOKUP   = 2'd1;
   localparam func_type FN_TOPN     = 2'd2;
   localparam func_type FN_RESERVED = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_MISS  = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_CLAMP = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [VAL_W-1:0] income;
      logic [VAL_W-1:0] volume;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SORT_RD_I,
      S_SORT_LAT_I,
      S_SORT_RD_P,
      S_SORT_CMP,
      S_EMIT_RD,
      S_EMIT_LAT,
      S_SHARE_GO,
      S_DIV_INC,
      S_DIV_VOL,
      S_OUT
   } state_type;

endpackage
`default_nettype wire

[rtl/ksh_ifs.sv]
// Interfaces: request and response channels of the keyed share table.
`default_nettype none
interface ksh_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   func;
   logic [ksh_pkg::ID_W-1:0]     asset_id;
   logic [ksh_pkg::VAL_W-1:0]    income;
   logic [ksh_pkg::VAL_W-1:0]    volume;
   logic [ksh_pkg::COUNT_W-1:0]  top_count;
   logic                         rank_by;
   logic                         descending;
   modport source (output valid, func, asset_id, income, volume, top_count, rank_by,
                   descending, input ready);
   modport sink (input valid, func, asset_id, income, volume, top_count, rank_by,
                 descending, output ready);
endinterface

interface ksh_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [ksh_pkg::ID_W-1:0]     out_id;
   logic [ksh_pkg::VAL_W-1:0]    out_income;
   logic [ksh_pkg::VAL_W-1:0]    out_volume;
   logic [ksh_pkg::FRAC_W-1:0]   income_share;
   logic [ksh_pkg::FRAC_W-1:0]   volume_share;
   logic                         last;
   modport source (output valid, status, out_id, out_income, out_volume, income_share,
                   volume_share, last, input ready);
   modport sink (input valid, status, out_id, out_income, out_volume, income_share,
                 volume_share, last, output ready);
endinterface
`default_nettype wire

[rtl/ksh_ram.sv]
// Entry memory: one write port, one registered read port.
`default_nettype none
module ksh_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 95
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/ksh_div.sv]
// Share divider: saturating 0.16 fraction part/total, one quotient bit a cycle.
`default_nettype none
module ksh_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ksh_pkg::VAL_W-1:0]   part,
   input  wire logic [ksh_pkg::TOT_W-1:0]   total,
   output logic                             done,
   output logic [ksh_pkg::FRAC_W-1:0]       quot
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [ksh_pkg::TOT_W-1:0]   rem_ff, rem_in;
   logic [ksh_pkg::TOT_W-1:0]   tot_ff, tot_in;
   logic [ksh_pkg::FRAC_W-1:0]  q_ff, q_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [ksh_pkg::TOT_W:0]     shifted;
   logic [ksh_pkg::TOT_W-1:0]   part_ext;

   assign part_ext = ksh_pkg::TOT_W'(part);
   assign shifted  = {rem_ff, 1'b0};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      tot_in  = tot_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         if (total == '0) begin
            q_in    = '0;
            done_in = 1'b1;
         end else if (part_ext >= total) begin
            // whole share or more: saturate
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = part_ext;
            tot_in  = total;
            q_in    = '0;
            cnt_in  = 5'(ksh_pkg::FRAC_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (shifted >= {1'b0, tot_ff}) begin
            rem_in = ksh_pkg::TOT_W'(shifted - {1'b0, tot_ff});
            q_in   = {q_ff[ksh_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[ksh_pkg::TOT_W-1:0];
            q_in   = {q_ff[ksh_pkg::FRAC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      tot_ff <= tot_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

[rtl/keyed_share_table_top_n.sv]
// Top level: keyed share table with lookups, updates and stable top-N ranking.
// Usage:
//   req_chan carries one command beat: update (func 0), lookup (func 1) or
//   top-N query (func 2); func 3 is dropped without a response.
//   rsp_chan returns one beat per update or lookup, and up to top_count
//   beats per top-N query, the final one flagged by last.
// Operation:
//   The block takes one command at a time; req_chan.ready is high only while
//   it waits for a command. Key search reads the entry memory one entry at a
//   time, a read state then a compare state. A hit or an appended entry then
//   passes through the shared divider, which forms the income share and
//   then the volume share, 16 quotient bits each.
//   A top-N query first insertion-sorts the memory in place, then reads each
//   reported entry before its shares.
// Reset clears the entry count and totals; the memory holds no reset value
// and only entries below the count are ever used.
// A stalled receiver holds the response beat in the output register; the
// block waits and accepts no new command until all beats have gone.
`default_nettype none
module keyed_share_table_top_n #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   ksh_req_if.sink   req_chan,
   ksh_rsp_if.source rsp_chan
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   ksh_pkg::state_type state_ff, state_in;

   logic [1:0]                  func_ff, func_in;
   logic [ksh_pkg::ID_W-1:0]    key_ff, key_in;
   logic [ksh_pkg::VAL_W-1:0]   inc_ff, inc_in;
   logic [ksh_pkg::VAL_W-1:0]   vol_ff, vol_in;
   logic [ksh_pkg::COUNT_W-1:0] want_ff, want_in;
   logic                        by_vol_ff, by_vol_in;
   logic                        desc_ff, desc_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [ksh_pkg::TOT_W-1:0]   itot_ff, itot_in;
   logic [ksh_pkg::TOT_W-1:0]   vtot_ff, vtot_in;
   logic [CNT_W-1:0]            ptr_ff, ptr_in;
   logic [ADDR_W-1:0]           j_ff, j_in;
   logic [CNT_W-1:0]            nemit_ff, nemit_in;
   ksh_pkg::entry_type          cur_ff, cur_in;
   ksh_pkg::entry_type          ent_ff, ent_in;
   ksh_pkg::status_type         status_ff, status_in;
   logic                        last_ff, last_in;
   logic [ksh_pkg::FRAC_W-1:0]  ishare_ff, ishare_in;
   logic [ksh_pkg::FRAC_W-1:0]  vshare_ff, vshare_in;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr, rd_addr;
   ksh_pkg::entry_type          wr_data, rd_data;

   logic                        div_start, div_done;
   logic [ksh_pkg::VAL_W-1:0]   div_part;
   logic [ksh_pkg::TOT_W-1:0]   div_total;
   logic [ksh_pkg::FRAC_W-1:0]  div_quot;

   logic                        req_fire, rsp_fire;
   logic                        hit, at_end, sort_done, move;
   logic [ksh_pkg::VAL_W-1:0]   key_prev, key_cur;
   logic                        clamp;
   logic [ksh_pkg::COUNT_W-1:0] n_emit;
   ksh_pkg::entry_type          new_entry;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign hit       = (rd_data.id == key_ff);
   assign at_end    = (ptr_ff == cnt_ff);
   assign sort_done = (ptr_ff >= cnt_ff);
   assign key_prev  = by_vol_ff ? rd_data.volume : rd_data.income;
   assign key_cur   = by_vol_ff ? cur_ff.volume : cur_ff.income;
   assign move      = desc_ff ? (key_prev < key_cur) : (key_prev > key_cur);
   assign clamp     = (want_ff > ksh_pkg::COUNT_W'(cnt_ff));
   assign n_emit    = clamp ? ksh_pkg::COUNT_W'(cnt_ff) : want_ff;
   assign new_entry = '{id: key_ff, income: inc_ff, volume: vol_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ksh_pkg::S_IDLE: begin
            if (req_fire) begin
               case (req_chan.func)
                  ksh_pkg::FN_UPDATE, ksh_pkg::FN_LOOKUP: state_in = ksh_pkg::S_SRCH_RD;
                  ksh_pkg::FN_TOPN:                       state_in = ksh_pkg::S_SORT_RD_I;
                  default:                                state_in = ksh_pkg::S_IDLE;
               endcase
            end
         end
         ksh_pkg::S_SRCH_RD: begin
            if (!at_end) begin
               state_in = ksh_pkg::S_SRCH_CMP;
            end else if (func_ff == ksh_pkg::FN_LOOKUP ||
                         cnt_ff == CNT_W'(TABLE_DEPTH)) begin
               state_in = ksh_pkg::S_OUT;
            end else begin
               state_in = ksh_pkg::S_SHARE_GO;
            end
         end
         ksh_pkg::S_SRCH_CMP: begin
            state_in = hit ? ksh_pkg::S_SHARE_GO : ksh_pkg::S_SRCH_RD;
         end
         ksh_pkg::S_SORT_RD_I: begin
            if (!sort_done) begin
               state_in = ksh_pkg::S_SORT_LAT_I;
            end else if (n_emit != '0) begin
               state_in = ksh_pkg::S_EMIT_RD;
            end else if (clamp) begin
               state_in = ksh_pkg::S_OUT;
            end else begin
               state_in = ksh_pkg::S_IDLE;
            end
         end
         ksh_pkg::S_SORT_LAT_I: state_in = ksh_pkg::S_SORT_RD_P;
         ksh_pkg::S_SORT_RD_P: begin
            state_in = (j_ff == '0) ? ksh_pkg::S_SORT_RD_I : ksh_pkg::S_SORT_CMP;
         end
         ksh_pkg::S_SORT_CMP: begin
            state_in = move ? ksh_pkg::S_SORT_RD_P : ksh_pkg::S_SORT_RD_I;
         end
         ksh_pkg::S_EMIT_RD:  state_in = ksh_pkg::S_EMIT_LAT;
         ksh_pkg::S_EMIT_LAT: state_in = ksh_pkg::S_SHARE_GO;
         ksh_pkg::S_SHARE_GO: state_in = ksh_pkg::S_DIV_INC;
         ksh_pkg::S_DIV_INC: begin
            if (div_done) begin
               state_in = ksh_pkg::S_DIV_VOL;
            end
         end
         ksh_pkg::S_DIV_VOL: begin
            if (div_done) begin
               state_in = ksh_pkg::S_OUT;
            end
         end
         ksh_pkg::S_OUT: begin
            if (rsp_fire) begin
               state_in = last_ff ? ksh_pkg::S_IDLE : ksh_pkg::S_EMIT_RD;
            end
         end
         default: state_in = ksh_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      func_in   = func_ff;
      key_in    = key_ff;
      inc_in    = inc_ff;
      vol_in    = vol_ff;
      want_in   = want_ff;
      by_vol_in = by_vol_ff;
      desc_in   = desc_ff;
      cnt_in    = cnt_ff;
      itot_in   = itot_ff;
      vtot_in   = vtot_ff;
      ptr_in    = ptr_ff;
      j_in      = j_ff;
      nemit_in  = nemit_ff;
      cur_in    = cur_ff;
      ent_in    = ent_ff;
      status_in = status_ff;
      last_in   = last_ff;
      ishare_in = ishare_ff;
      vshare_in = vshare_ff;
      wr_en     = 1'b0;
      wr_addr   = j_ff;
      wr_data   = cur_ff;
      rd_addr   = ptr_ff[ADDR_W-1:0];
      div_start = 1'b0;
      div_part  = ent_ff.income;
      div_total = itot_ff;
      case (state_ff)
         ksh_pkg::S_IDLE: begin
            if (req_fire) begin
               func_in   = req_chan.func;
               key_in    = req_chan.asset_id;
               inc_in    = req_chan.income;
               vol_in    = req_chan.volume;
               want_in   = req_chan.top_count;
               by_vol_in = req_chan.rank_by;
               desc_in   = req_chan.descending;
               ptr_in    = (req_chan.func == ksh_pkg::FN_TOPN) ? CNT_W'(1) : '0;
            end
         end
         ksh_pkg::S_SRCH_RD: begin
            if (at_end) begin
               last_in = 1'b1;
               if (func_ff == ksh_pkg::FN_LOOKUP) begin
                  status_in = ksh_pkg::ST_MISS;
                  ent_in    = '0;
                  ishare_in = '0;
                  vshare_in = '0;
               end else if (cnt_ff == CNT_W'(TABLE_DEPTH)) begin
                  status_in = ksh_pkg::ST_FULL;
                  ent_in    = '0;
                  ishare_in = '0;
                  vshare_in = '0;
               end else begin
                  // append new key
                  wr_en     = 1'b1;
                  wr_addr   = cnt_ff[ADDR_W-1:0];
                  wr_data   = new_entry;
                  cnt_in    = cnt_ff + CNT_W'(1);
                  itot_in   = itot_ff + ksh_pkg::TOT_W'(inc_ff);
                  vtot_in   = vtot_ff + ksh_pkg::TOT_W'(vol_ff);
                  ent_in    = new_entry;
                  status_in = ksh_pkg::ST_OK;
               end
            end
         end
         ksh_pkg::S_SRCH_CMP: begin
            if (hit) begin
               status_in = ksh_pkg::ST_OK;
               last_in   = 1'b1;
               if (func_ff == ksh_pkg::FN_UPDATE) begin
                  wr_en   = 1'b1;
                  wr_addr = ptr_ff[ADDR_W-1:0];
                  wr_data = new_entry;
                  itot_in = itot_ff - ksh_pkg::TOT_W'(rd_data.income)
                            + ksh_pkg::TOT_W'(inc_ff);
                  vtot_in = vtot_ff - ksh_pkg::TOT_W'(rd_data.volume)
                            + ksh_pkg::TOT_W'(vol_ff);
                  ent_in  = new_entry;
               end else begin
                  ent_in = rd_data;
               end
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         ksh_pkg::S_SORT_RD_I: begin
            if (sort_done) begin
               nemit_in  = CNT_W'(n_emit);
               status_in = clamp ? ksh_pkg::ST_CLAMP : ksh_pkg::ST_OK;
               ptr_in    = '0;
               if (n_emit == '0) begin
                  ent_in    = '0;
                  ishare_in = '0;
                  vshare_in = '0;
                  last_in   = 1'b1;
               end
            end
         end
         ksh_pkg::S_SORT_LAT_I: begin
            cur_in = rd_data;
            j_in   = ptr_ff[ADDR_W-1:0];
         end
         ksh_pkg::S_SORT_RD_P: begin
            if (j_ff == '0) begin
               wr_en  = 1'b1;
               ptr_in = ptr_ff + CNT_W'(1);
            end else begin
               rd_addr = j_ff - ADDR_W'(1);
            end
         end
         ksh_pkg::S_SORT_CMP: begin
            wr_en = 1'b1;
            if (move) begin
               // shift the out-of-order neighbor up one slot
               wr_data = rd_data;
               j_in    = j_ff - ADDR_W'(1);
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         ksh_pkg::S_EMIT_LAT: begin
            ent_in  = rd_data;
            last_in = ((ptr_ff + CNT_W'(1)) == nemit_ff);
         end
         ksh_pkg::S_SHARE_GO: begin
            div_start = 1'b1;
         end
         ksh_pkg::S_DIV_INC: begin
            if (div_done) begin
               ishare_in = div_quot;
               div_start = 1'b1;
               div_part  = ent_ff.volume;
               div_total = vtot_ff;
            end
         end
         ksh_pkg::S_DIV_VOL: begin
            if (div_done) begin
               vshare_in = div_quot;
            end
         end
         ksh_pkg::S_OUT: begin
            if (rsp_fire && !last_ff) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ksh_pkg::S_IDLE;
         cnt_ff   <= '0;
         itot_ff  <= '0;
         vtot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         itot_ff  <= itot_in;
         vtot_ff  <= vtot_in;
      end
      func_ff   <= func_in;
      key_ff    <= key_in;
      inc_ff    <= inc_in;
      vol_ff    <= vol_in;
      want_ff   <= want_in;
      by_vol_ff <= by_vol_in;
      desc_ff   <= desc_in;
      ptr_ff    <= ptr_in;
      j_ff      <= j_in;
      nemit_ff  <= nemit_in;
      cur_ff    <= cur_in;
      ent_ff    <= ent_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      ishare_ff <= ishare_in;
      vshare_ff <= vshare_in;
   end

   ksh_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH ($bits(ksh_pkg::entry_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ksh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .part  (div_part),
      .total (div_total),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_chan.ready        = (state_ff == ksh_pkg::S_IDLE);
   assign rsp_chan.valid        = (state_ff == ksh_pkg::S_OUT);
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.out_id       = ent_ff.id;
   assign rsp_chan.out_income   = ent_ff.income;
   assign rsp_chan.out_volume   = ent_ff.volume;
   assign rsp_chan.income_share = ishare_ff;
   assign rsp_chan.volume_share = vshare_ff;
   assign rsp_chan.last         = last_ff;

endmodule
`default_nettype wire
